FILE: src/range_assign_total_sum_unit_assert.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef RANGE_ASSIGN_TOTAL_SUM_UNIT_ASSERT_SVH
`define RANGE_ASSIGN_TOTAL_SUM_UNIT_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle.
`define RATS_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Condition in this cycle implies consequence in the next cycle.
`define RATS_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/rats_pkg.sv
// ----------------------------------------------------------------------------
// rats_pkg
// Shared widths and constants of the range assign total sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rats_pkg;
  localparam int unsigned PosW   = 11;
  localparam int unsigned ValW   = 8;
  localparam int unsigned TotalW = 18;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned AddrW  = 3;
  localparam logic [PosW-1:0] SizeReset = 11'd1024;
  localparam logic [ValW-1:0] InitVal   = 8'd1;
  localparam logic            FuncInit  = 1'b0;
  localparam logic            RegSize   = 1'b0;
endpackage

`default_nettype wire

FILE: src/range_assign_total_sum_unit.sv
// ----------------------------------------------------------------------------
// range_assign_total_sum_unit
// Range assign over positions 1..n with the running total of all positions.
// ----------------------------------------------------------------------------
// Input items come on s_t*: tuser holds func, tdata holds left, right, value.
// Func initialize sets every position to one; func assign writes value to
// positions left..right. Each item gives one result on m_t*: tdata holds the
// total of positions 1..n, tuser the bad_range flag.
// The position values live in one memory; an assign sweeps its range one
// position per cycle (read, then write back with the total corrected). An
// initialize rewrites the whole memory. Reset and each write of size_in_use
// run the same clearing pass with no result; s_tready stays low meanwhile.
// The result register holds while m_tready is low; the next item may be
// accepted then, and its result waits until the register frees.
// size_in_use sits at APB address 0; only paddr[2] is decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module range_assign_total_sum_unit #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [31:0]              s_tdata,  // left, right, value
  input  wire logic [0:0]               s_tuser,  // func
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [23:0]                   m_tdata,  // total
  output logic [0:0]                    m_tuser,  // bad_range
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [rats_pkg::AddrW-1:0] paddr,
  input  wire logic [rats_pkg::CfgW-1:0]  pwdata,
  output logic [rats_pkg::CfgW-1:0]       prdata,
  output logic                          pready
);
  import rats_pkg::*;

  localparam int unsigned AW   = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int unsigned NW   = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned CMPW = (NW > PosW) ? NW : PosW;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_ASSIGN, ST_FINISH} state_t;

  state_t            state;
  logic [PosW-1:0]   size_in_use;
  logic [AW-1:0]     clr_addr;
  logic              emit;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     end_addr;
  logic              rd_done;
  logic              wr_pend;
  logic [AW-1:0]     wr_addr;
  logic [ValW-1:0]   val;
  logic [TotalW-1:0] total;
  logic [TotalW-1:0] total_next;
  logic              bad;
  logic [TotalW-1:0] m_total;
  logic              m_bad;

  logic [PosW-1:0]   in_left;
  logic [PosW-1:0]   in_right;
  logic [ValW-1:0]   in_value;
  logic [CMPW-1:0]   size_ext;
  logic [CMPW-1:0]   n_active;
  logic              in_bad;
  logic              cfg_wr;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ValW-1:0]   mem_wdata;
  logic              mem_re;
  logic [ValW-1:0]   mem_rdata;

  assign in_left  = s_tdata[PosW-1:0];
  assign in_right = s_tdata[2*PosW-1:PosW];
  assign in_value = s_tdata[2*PosW+ValW-1:2*PosW];
  assign size_ext = CMPW'(size_in_use);

  always_comb begin
    if (size_ext == '0) begin
      n_active = CMPW'(1);
    end else if (size_ext > CMPW'(MAX_POSITIONS)) begin
      n_active = CMPW'(MAX_POSITIONS);
    end else begin
      n_active = size_ext;
    end
  end

  assign in_bad = (in_left == '0) || (in_left > in_right) ||
                  (CMPW'(in_right) > n_active);

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = CfgW'(size_in_use);
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == RegSize);
  assign m_tdata  = 24'(m_total);
  assign m_tuser  = m_bad;

  assign total_next = total + TotalW'(val) - TotalW'(mem_rdata);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = val;
    mem_re    = (state == ST_ASSIGN) && !rd_done;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = InitVal;
    end else if (state == ST_ASSIGN && wr_pend) begin
      mem_we = 1'b1;
    end
  end

  rats_ram #(
    .DEPTH(MAX_POSITIONS),
    .AW   (AW),
    .DW   (ValW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      size_in_use <= SizeReset;
      clr_addr    <= '0;
      emit        <= 1'b0;
      rd_done     <= 1'b1;
      wr_pend     <= 1'b0;
      m_tvalid    <= 1'b0;
      total       <= '0;
      bad         <= 1'b0;
    end else if (cfg_wr) begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      size_in_use <= pwdata[PosW-1:0];
      clr_addr    <= '0;
      emit        <= 1'b0;
      state       <= ST_CLEAR;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_POSITIONS - 1)) begin
            total <= TotalW'(n_active);
            bad   <= 1'b0;
            state <= emit ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser[0] == FuncInit) begin
              clr_addr <= '0;
              emit     <= 1'b1;
              state    <= ST_CLEAR;
            end else if (in_bad) begin
              bad   <= 1'b1;
              state <= ST_FINISH;
            end else begin
              rd_addr  <= AW'(in_left - PosW'(1));
              end_addr <= AW'(in_right - PosW'(1));
              val      <= in_value;
              rd_done  <= 1'b0;
              wr_pend  <= 1'b0;
              bad      <= 1'b0;
              state    <= ST_ASSIGN;
            end
          end
        end
        ST_ASSIGN: begin
          wr_pend <= !rd_done;
          wr_addr <= rd_addr;
          if (!rd_done) begin
            rd_addr <= rd_addr + AW'(1);
            if (rd_addr == end_addr) begin
              rd_done <= 1'b1;
            end
          end
          if (wr_pend) begin
            total <= total_next;
          end
          if (rd_done && !wr_pend) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_total  <= total;
            m_bad    <= bad;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "range_assign_total_sum_unit_assert.svh"

  `RATS_ASSERT_NOW(a_no_same_entry, mem_re && mem_we, rd_addr != mem_waddr)
  `RATS_ASSERT_NOW(a_wr_in_range, state == ST_ASSIGN && wr_pend, wr_addr <= end_addr)
  `RATS_ASSERT_NEXT(a_bad_keeps_total, state == ST_IDLE && s_tvalid && s_tuser[0] != FuncInit
                    && in_bad && !cfg_wr, $stable(total) && bad)

endmodule

`default_nettype wire

FILE: src/rats_ram.sv
// ----------------------------------------------------------------------------
// rats_ram
// Position value memory: one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rats_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

FILE: dv/range_assign_total_sum_unit_test.sv
// ----------------------------------------------------------------------------
// range_assign_total_sum_unit_test
// Self-checking bench: directed table, then random items per size.
// ----------------------------------------------------------------------------
// A flat array of position values predicts the running total and the
// bad_range flag of every item without a typed-in result. The size
// register is rewritten between phases while the block is idle, and the
// idle rates of both stream sides vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_assign_total_sum_unit_test;
  import rats_pkg::*;

  localparam logic FuncAssign = 1'b1;
  localparam int   MaxPos     = 1024;
  localparam int   StallLimit = 20000;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic              bad;
  } sum_result_t;

  typedef struct {
    logic            func;
    logic [PosW-1:0] left;
    logic [PosW-1:0] right;
    logic [ValW-1:0] value;
    bit              fixed;
    int              total;
    bit              bad;
  } range_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;
  logic [0:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [CfgW-1:0]   pwdata = '0;
  logic [CfgW-1:0]   prdata;
  logic              pready;

  bit                cur_fixed = 0;
  sum_result_t       cur_result = '0;

  logic [ValW-1:0]   cells [1:MaxPos];
  int                size_n;
  sum_result_t       pending_sums [$];
  int                errors = 0;
  int                send_idle = 19;
  int                recv_idle = 80;
  int                hold_cycles = 0;
  int                stall_count = 0;

  always #2 clk = ~clk;

  range_assign_total_sum_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic void fill_ones(logic [CfgW-1:0] size_reg);
    int n;
    n = int'(size_reg & 32'h7FF);
    if (n < 1) n = 1;
    if (n > MaxPos) n = MaxPos;
    size_n = n;
    for (int i = 1; i <= MaxPos; i++) cells[i] = InitVal;
  endfunction

  function automatic sum_result_t apply_range(logic func, logic [PosW-1:0] left,
                                              logic [PosW-1:0] right,
                                              logic [ValW-1:0] value);
    sum_result_t res;
    int acc;
    res = '0;
    acc = 0;
    if (func == FuncInit) begin
      for (int i = 1; i <= MaxPos; i++) cells[i] = InitVal;
    end else if (left == 0 || left > right || right > size_n) begin
      res.bad = 1'b1;
    end else begin
      for (int i = int'(left); i <= int'(right); i++) cells[i] = value;
    end
    for (int i = 1; i <= size_n; i++) acc += cells[i];
    res.total = acc[TotalW-1:0];
    return res;
  endfunction

  // accepted input: predict, or take the typed-in result
  always @(posedge clk) begin
    sum_result_t res;
    if (!rst && s_tvalid && s_tready) begin
      res = apply_range(s_tuser[0], s_tdata[10:0], s_tdata[21:11], s_tdata[29:22]);
      if (cur_fixed) res = cur_result;
      pending_sums.push_back(res);
    end
  end

  always @(posedge clk) begin
    sum_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result total=%0d bad=%0b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (m_tdata !== {6'b0, want.total} || m_tuser[0] !== want.bad) begin
          $display("%0t: mismatch expected total=%0d bad=%0b, got total=%0d bad=%0b",
                   $time, want.total, want.bad, m_tdata, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) stall_count = 0;
    else stall_count++;
    if (stall_count >= StallLimit) begin
      $display("%0t: timeout, no progress", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(range_item_t it);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = it.func;
    s_tdata = {2'b0, it.value, it.right, it.left};
    cur_fixed = it.fixed;
    cur_result.total = it.total[TotalW-1:0];
    cur_result.bad = it.bad;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain();
    wait (pending_sums.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_size(logic [CfgW-1:0] size_reg);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = {RegSize, 2'b00}; pwdata = size_reg;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    fill_ones(size_reg);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic range_item_t rand_item();
    range_item_t it;
    int roll, l, w;
    it.fixed = 0; it.total = 0; it.bad = 0;
    it.func = FuncAssign;
    it.value = ValW'($urandom_range(0, 255));
    roll = $urandom_range(99);
    if (roll < 5) begin
      it.func = FuncInit;
      it.left = PosW'($urandom); it.right = PosW'($urandom);
    end else if (roll < 14) begin
      it.left = PosW'($urandom); it.right = PosW'($urandom);
    end else begin
      l = $urandom_range(1, size_n);
      w = ($urandom_range(3) == 0) ? size_n - l : $urandom_range(0, 40);
      if (l + w > size_n) w = size_n - l;
      it.left = PosW'(l);
      it.right = PosW'(l + w);
    end
    return it;
  endfunction

  range_item_t steps [] = '{
    '{FuncAssign, 11'd1,    11'd1,    8'd255, 1, 1278,   0},
    '{FuncInit,   11'd0,    11'd0,    8'd0,   1, 1024,   0},
    '{FuncAssign, 11'd1,    11'd1024, 8'd255, 1, 261120, 0},
    '{FuncAssign, 11'd0,    11'd5,    8'd7,   1, 261120, 1},
    '{FuncAssign, 11'd5,    11'd4,    8'd7,   1, 261120, 1},
    '{FuncAssign, 11'd1,    11'd1025, 8'd7,   1, 261120, 1},
    '{FuncAssign, 11'd2047, 11'd2047, 8'd7,   1, 261120, 1},
    '{FuncAssign, 11'd1,    11'd1024, 8'd0,   1, 0,      0},
    '{FuncInit,   11'd2047, 11'd2047, 8'd255, 1, 1024,   0},
    '{FuncAssign, 11'd512,  11'd513,  8'd128, 0, 0,      0},
    '{FuncAssign, 11'd1024, 11'd1024, 8'd1,   0, 0,      0},
    '{FuncAssign, 11'd1,    11'd512,  8'hAA,  0, 0,      0},
    '{FuncAssign, 11'd300,  11'd700,  8'h55,  0, 0,      0},
    '{FuncAssign, 11'd2,    11'd1023, 8'd3,   0, 0,      0},
    '{FuncAssign, 11'd1023, 11'd1024, 8'd254, 0, 0,      0}
  };

  logic [CfgW-1:0] sizes [6] = '{32'd1, 32'd2047, 32'd7, 32'd0, 32'd1000, 32'd1024};

  initial begin
    fill_ones(CfgW'(SizeReset));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (steps[i]) send_item(steps[i]);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_size(sizes[ph]);
      send_idle = (ph < 2) ? 19 : (ph < 4) ? 80 : 0;
      recv_idle = (ph < 2) ? 80 : (ph < 4) ? 19 : 0;
      if (ph == 4) hold_cycles = 400;
      for (int k = 0; k < 215; k++) begin
        if (ph == 5 && k == 100) wait (pending_sums.size() == 0);
        send_item(rand_item());
      end
    end
    cur_fixed = 0;
    wait (pending_sums.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

`default_nettype wire

FILE: range_assign_total_sum_unit.f
+incdir+src
src/rats_pkg.sv
src/rats_ram.sv
src/range_assign_total_sum_unit.sv
dv/range_assign_total_sum_unit_test.sv
